// ===== src/rlid_pkg.sv =====
// Shared types and constants for the run-length image decoder.
package rlid_pkg;

	// Reset values of the configuration registers.
	localparam logic [7:0]  HeaderBytesRst  = 8'd3;
	localparam logic [15:0] FramePixelsRst  = 16'd64000;

	// Configuration register indexes.
	localparam int unsigned CfgIndexWidth   = 2;
	localparam logic [CfgIndexWidth-1:0] CfgHeaderBytes = 2'd0;
	localparam logic [CfgIndexWidth-1:0] CfgFramePixels = 2'd1;
	localparam int unsigned CfgDataWidth    = 16;

	// Command byte classes.
	localparam logic [7:0] CmdLongRun       = 8'd0;
	localparam logic [7:0] CmdLiteralLast   = 8'd14;
	localparam logic [7:0] CmdRepeatFirst   = 8'd128;

	// Default depth of the queue between parser and run emitter.
	localparam int unsigned QueueDepthDef   = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       new_frame;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  pixel_value;
		logic [15:0] run_length;
		logic [15:0] start_index;
		logic        frame_done;
	} out_item_t;

	// One parsed event: an optional frame start and an optional run request.
	typedef struct packed {
		logic        frame_start;
		logic        run;
		logic [7:0]  value;
		logic [15:0] count;
	} run_req_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_stat_t;

endpackage

// ===== src/rlid_front.sv =====
// Byte parser: skips the header, decodes commands and issues run requests.
module rlid_front import rlid_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  header_bytes,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	input  queue_stat_t q_stat,
	output logic        push,
	output run_req_t    push_data
);

	localparam logic [2:0] PhHeader  = 3'd0;
	localparam logic [2:0] PhCommand = 3'd1;
	localparam logic [2:0] PhCntHigh = 3'd2;
	localparam logic [2:0] PhCntLow  = 3'd3;
	localparam logic [2:0] PhValue   = 3'd4;
	localparam logic [2:0] PhLiteral = 3'd5;
	localparam logic [2:0] PhRepeat  = 3'd6;

	logic [2:0]  phase_q, phase_d, ph;
	logic [7:0]  header_left_q, header_left_d, hl;
	logic [7:0]  count_high_q, count_high_d, ch;
	logic [15:0] pending_q, pending_d, pc;
	logic [3:0]  literal_left_q, literal_left_d, lit;
	logic        accept;
	logic        run_vld;
	logic [15:0] run_cnt;
	logic [7:0]  b;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign b        = in_data.data_byte;

	always_comb begin
		// A new frame restarts the parser before its first byte is decoded.
		ph  = phase_q;
		hl  = header_left_q;
		ch  = count_high_q;
		pc  = pending_q;
		lit = literal_left_q;
		if (in_data.new_frame) begin
			hl  = header_bytes;
			ph  = (header_bytes != 8'd0) ? PhHeader : PhCommand;
			ch  = 8'd0;
			pc  = 16'd0;
			lit = 4'd0;
		end
		phase_d        = ph;
		header_left_d  = hl;
		count_high_d   = ch;
		pending_d      = pc;
		literal_left_d = lit;
		run_vld        = 1'b0;
		run_cnt        = pc;
		if (ph == PhCommand || (ph == PhHeader && hl == 8'd0)) begin
			if (b == CmdLongRun) begin
				phase_d = PhCntHigh;
			end else if (b <= CmdLiteralLast) begin
				literal_left_d = b[3:0];
				phase_d = PhLiteral;
			end else if (b >= CmdRepeatFirst) begin
				pending_d = 16'(9'd256 - {1'b0, b});
				phase_d = PhRepeat;
			end else begin
				phase_d = PhCommand;
			end
		end else begin
			case (ph)
				PhHeader: begin
					header_left_d = hl - 8'd1;
					if (hl == 8'd1) begin
						phase_d = PhCommand;
					end
				end
				PhCntHigh: begin
					count_high_d = b;
					phase_d = PhCntLow;
				end
				PhCntLow: begin
					pending_d = {ch, b};
					phase_d = PhValue;
				end
				PhValue, PhRepeat: begin
					phase_d = PhCommand;
					run_vld = 1'b1;
				end
				PhLiteral: begin
					literal_left_d = lit - 4'd1;
					phase_d = (lit == 4'd1) ? PhCommand : PhLiteral;
					run_vld = 1'b1;
					run_cnt = 16'd1;
				end
				default: begin
					phase_d = PhCommand;
				end
			endcase
		end
	end

	// Only frame starts and nonempty runs need the emitter.
	always_comb begin
		push_data.frame_start = in_data.new_frame;
		push_data.run         = run_vld && (run_cnt != 16'd0);
		push_data.value       = b;
		push_data.count       = run_cnt;
		push = accept && (push_data.frame_start || push_data.run);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PhHeader;
			header_left_q  <= HeaderBytesRst;
			count_high_q   <= 8'd0;
			pending_q      <= 16'd0;
			literal_left_q <= 4'd0;
		end else if (accept) begin
			phase_q        <= phase_d;
			header_left_q  <= header_left_d;
			count_high_q   <= count_high_d;
			pending_q      <= pending_d;
			literal_left_q <= literal_left_d;
		end
	end

endmodule

// ===== src/rlid_queue.sv =====
// Small FIFO of run requests between the parser and the run emitter.
module rlid_queue import rlid_pkg::*; #(
	parameter int unsigned Depth = QueueDepthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  run_req_t    push_data,
	input  logic        pop,
	output run_req_t    head,
	output queue_stat_t stat
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	run_req_t        mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push, do_pop;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == FullCnt);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

// ===== src/rlid_back.sv =====
// Run emitter: tracks the frame position, clips runs and holds the result register.
module rlid_back import rlid_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] frame_pixels,
	input  run_req_t    head,
	input  queue_stat_t q_stat,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data
);

	logic [15:0] position_q, pos, room, len;
	logic        finished_q, fin;
	logic        out_valid_q;
	out_item_t   out_q;
	logic        emit, fin_d;
	logic [15:0] position_d;

	assign pop       = !q_stat.empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		pos        = head.frame_start ? 16'd0 : position_q;
		fin        = head.frame_start ? 1'b0 : finished_q;
		room       = frame_pixels - pos;
		len        = (head.count < room) ? head.count : room;
		emit       = 1'b0;
		fin_d      = fin;
		position_d = pos;
		if (head.run && !fin) begin
			if (pos >= frame_pixels) begin
				fin_d = 1'b1;
			end else begin
				emit       = 1'b1;
				position_d = pos + len;
				fin_d      = (len == room);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q  <= 16'd0;
			finished_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				position_q  <= position_d;
				finished_q  <= fin_d;
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_q.pixel_value <= head.value;
			out_q.run_length  <= len;
			out_q.start_index <= pos;
			out_q.frame_done  <= (len == room);
		end
	end

endmodule

// ===== src/rle_image_run_decoder.sv =====
// Top level of the run-length image decoder: configuration, parser, queue and emitter.
//
// The decoder takes one compressed byte per clock cycle while in_ready is high and
// returns each decoded run inside the frame as a transaction carrying its pixel value,
// clipped length, start index and a done flag for the run that reaches the end of the
// frame. A parser accepts bytes, skips the frame header and decodes commands; each frame
// start and each nonempty run is written into a short queue. An emitter drains the queue
// one entry per cycle unless the output stalls, keeps the frame position, clips runs at
// frame_pixels and loads a result register. Bytes flow at a sustained rate of one per
// cycle while the output side keeps up; a completed run is written into the queue and
// then popped into the result register, which drives out_valid. When the output is
// stalled, the queue (QueueDepth entries) keeps absorbing bytes until it fills, and
// in_ready then drops. header_bytes takes effect at the next new frame; frame_pixels is
// used for every run. Write the configuration only while no transaction is pending.
module rle_image_run_decoder import rlid_pkg::*; #(
	parameter int unsigned QueueDepth = QueueDepthDef
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CfgIndexWidth-1:0] cfg_index,
	input  logic [CfgDataWidth-1:0]  cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  in_item_t                 in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output out_item_t                out_data
);

	logic [7:0]  header_bytes_q;
	logic [15:0] frame_pixels_q;
	logic        push, pop;
	run_req_t    push_data, head;
	queue_stat_t q_stat;

	// Configuration registers; writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_bytes_q <= HeaderBytesRst;
			frame_pixels_q <= FramePixelsRst;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CfgHeaderBytes: header_bytes_q <= cfg_data[7:0];
				CfgFramePixels: frame_pixels_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// The parser only needs queue space; it never waits for the emitter otherwise.
	rlid_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.header_bytes (header_bytes_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.q_stat       (q_stat),
		.push         (push),
		.push_data    (push_data)
	);

	rlid_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	// The emitter pops whenever its result register is free or being drained.
	rlid_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_pixels (frame_pixels_q),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data)
	);

endmodule

// ===== src/rlid_checker.sv =====
// Port-level assertions for the run-length image decoder and their bind.
module rlid_checker import rlid_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// A stalled result keeps its content.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Zero-length runs never leave the block.
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.run_length != 16'd0)
		else $error("empty run delivered");

	// A clipped run never extends past the largest frame.
	a_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, out_data.start_index} + {1'b0, out_data.run_length})
			<= 17'd65535)
		else $error("run extends past the position range");

	// Nothing is shown right after reset is released.
	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result present after reset");

endmodule

bind rle_image_run_decoder rlid_checker u_rlid_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
